### src/mecanum_drive_mixer_line_follow_macros.svh
// assertion macros shared by the mecanum mixer rtl
// no dependencies; included by files that carry assertions
`ifndef MECANUM_DRIVE_MIXER_LINE_FOLLOW_MACROS_SVH
`define MECANUM_DRIVE_MIXER_LINE_FOLLOW_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define MDMLF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mdmlf assertion failed");

// next-cycle implication
`define MDMLF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mdmlf assertion failed");

`else

`define MDMLF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MDMLF_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

### src/mdmlf_pkg.sv
// types, codes and constants of the mecanum mixer with line following
// no dependencies
`timescale 1ns / 1ps

package mdmlf_pkg;

  localparam int unsigned DRIVE_LIMIT = 255;
  localparam int unsigned MAG_W       = 8;
  localparam int unsigned MAG_MAX     = (2 ** MAG_W) - 1;
  localparam int unsigned CMD_W       = 24;  // command width, signed q.8
  localparam int unsigned MIX_W       = 26;  // mixed wheel value, signed q.8
  localparam int unsigned FWD_W       = 19;  // stored forward command, q10.8
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 12;
  localparam int unsigned RATE_ONE    = 256;

  typedef enum logic [1:0] {
    MODE_STICKS = 2'd0,
    MODE_RAMP   = 2'd1,
    MODE_FIXED  = 2'd2,
    MODE_SLIDE  = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_LATERAL    = 3'd0,
    CFG_GAIN_ROTATE     = 3'd1,
    CFG_OFFSET_LATERAL  = 3'd2,
    CFG_OFFSET_ROTATE   = 3'd3,
    CFG_LINE_CENTER_SUM = 3'd4,
    CFG_LINE_LOST_CODE  = 3'd5,
    CFG_RAMP_RATE       = 3'd6
  } cfg_idx_e;

  localparam logic [11:0]       RST_GAIN_LATERAL    = 12'd230;
  localparam logic [11:0]       RST_GAIN_ROTATE     = 12'd205;
  localparam logic signed [7:0] RST_OFFSET_LATERAL  = -8'sd1;
  localparam logic signed [7:0] RST_OFFSET_ROTATE   = 8'sd5;
  localparam logic [8:0]        RST_LINE_CENTER_SUM = 9'd126;
  localparam logic [7:0]        RST_LINE_LOST_CODE  = 8'd21;
  localparam logic [8:0]        RST_RAMP_RATE       = 9'd26;

  // 64.0 in q.8
  localparam logic signed [FWD_W-1:0] FWD_CENTRE = 19'sd16384;

  typedef struct packed {
    logic [1:0]        mode;
    logic [7:0]        front_sensor;
    logic [7:0]        rear_sensor;
    logic [7:0]        stick_forward;
    logic [7:0]        stick_lateral;
    logic [7:0]        stick_rotate;
    logic signed [7:0] forward_offset;
    logic signed [7:0] lateral_offset;
    logic              stop_on_line_loss;
  } in_t;

  typedef struct packed {
    logic [7:0] rf_magnitude;
    logic       rf_reverse;
    logic [7:0] rr_magnitude;
    logic       rr_reverse;
    logic [7:0] lf_magnitude;
    logic       lf_reverse;
    logic [7:0] lr_magnitude;
    logic       lr_reverse;
  } out_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
    logic             pos;
  } drive_t;

endpackage

### src/mdmlf_wheel_drive.sv
// one wheel: truncate a signed q.8 mix toward zero, saturate, split into level and sign
// depends on mdmlf_pkg
`timescale 1ns / 1ps

module mdmlf_wheel_drive #(
  parameter int unsigned DriveLimit = mdmlf_pkg::DRIVE_LIMIT
) (
  input  logic signed [mdmlf_pkg::MIX_W-1:0] mix_i,
  output mdmlf_pkg::drive_t                  drive_o
);
  import mdmlf_pkg::*;

  localparam int unsigned IntW = MIX_W - 8;
  localparam int unsigned Lim  = (DriveLimit < MAG_MAX) ? DriveLimit : MAG_MAX;
  localparam logic [IntW-1:0] LimV = IntW'(Lim);

  logic signed [MIX_W-1:0] adj;
  logic signed [IntW-1:0]  whole;
  logic [IntW-1:0]         absval;

  always_comb begin
    // bias negatives so the arithmetic shift truncates toward zero
    adj    = mix_i + (mix_i[MIX_W-1] ? MIX_W'(255) : MIX_W'(0));
    whole  = adj[MIX_W-1:8];
    absval = whole[IntW-1] ? IntW'(-whole) : IntW'(whole);
    drive_o.mag = (absval > LimV) ? MAG_W'(LimV) : MAG_W'(absval);
    drive_o.neg = whole[IntW-1];
    drive_o.pos = !whole[IntW-1] && (whole != '0);
  end

endmodule

### src/mecanum_drive_mixer_line_follow.sv
// top level of the mecanum wheel mixer with line following
// depends on mdmlf_pkg, mdmlf_wheel_drive and the assertion macro header
`timescale 1ns / 1ps

// usage
//  - in channel (in_valid_i / in_ready_o / in_data_i): one control tick per
//    transaction: mode, two line sensors, sticks and forward/lateral offsets
//  - out channel (out_valid_o / out_ready_i / out_data_o): one transaction per
//    tick with level and direction for the four wheels
//  - cfg channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i):
//    register writes, always ready; index 7 is ignored; write only while idle
//  - a tick is registered in the input stage on accept and its result is
//    registered in the result stage once that stage is free
//  - throughput: one tick per cycle unless stalled; ramp feedback (forward
//    command, multiply by ramp rate, add) closes in the single compute stage
//  - stall: with the output register full and out_ready_i low, the input
//    register still takes one more tick, then in_ready_o drops until the
//    receiver takes a result
//  - reset: both stages empty, registers at their defaults, forward command
//    back to the 64.0 centre value
module mecanum_drive_mixer_line_follow #(
  parameter int unsigned DriveLimit = mdmlf_pkg::DRIVE_LIMIT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  mdmlf_pkg::in_t                      in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output mdmlf_pkg::out_t                     out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mdmlf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mdmlf_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import mdmlf_pkg::*;

  `include "mecanum_drive_mixer_line_follow_macros.svh"

  localparam logic signed [CMD_W-1:0] CmdCentre = CMD_W'(64 * 256);
  localparam logic signed [MIX_W-1:0] Mix64     = MIX_W'(64 * 256);
  localparam logic signed [MIX_W-1:0] Mix192    = MIX_W'(192 * 256);

  // configuration registers
  logic [11:0]        gain_lateral_q;
  logic [11:0]        gain_rotate_q;
  logic signed [7:0]  offset_lateral_q;
  logic signed [7:0]  offset_rotate_q;
  logic [8:0]         line_center_sum_q;
  logic [7:0]         line_lost_code_q;
  logic [8:0]         ramp_rate_q;

  // pipeline state
  logic                    s1_valid_q;
  in_t                     s1_q;
  logic                    out_valid_q;
  out_t                    out_q;
  logic signed [FWD_W-1:0] forward_cmd_q;
  out_t                    out_d;
  logic signed [FWD_W-1:0] forward_cmd_d;

  logic out_free;
  logic advance;
  logic in_fire;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;
  assign advance     = s1_valid_q && out_free;
  assign in_ready_o  = !s1_valid_q || out_free;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_lateral_q    <= RST_GAIN_LATERAL;
      gain_rotate_q     <= RST_GAIN_ROTATE;
      offset_lateral_q  <= RST_OFFSET_LATERAL;
      offset_rotate_q   <= RST_OFFSET_ROTATE;
      line_center_sum_q <= RST_LINE_CENTER_SUM;
      line_lost_code_q  <= RST_LINE_LOST_CODE;
      ramp_rate_q       <= RST_RAMP_RATE;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_GAIN_LATERAL:    gain_lateral_q    <= cfg_data_i[11:0];
        CFG_GAIN_ROTATE:     gain_rotate_q     <= cfg_data_i[11:0];
        CFG_OFFSET_LATERAL:  offset_lateral_q  <= cfg_data_i[7:0];
        CFG_OFFSET_ROTATE:   offset_rotate_q   <= cfg_data_i[7:0];
        CFG_LINE_CENTER_SUM: line_center_sum_q <= cfg_data_i[8:0];
        CFG_LINE_LOST_CODE:  line_lost_code_q  <= cfg_data_i[7:0];
        CFG_RAMP_RATE:       ramp_rate_q       <= cfg_data_i[8:0];
        default: begin
        end
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_data_i;
    end
  end

  // command forming
  logic signed [9:0]        sens_diff;
  logic signed [10:0]       sens_err;
  logic signed [CMD_W-1:0]  lat_prod;
  logic signed [CMD_W-1:0]  rot_prod;
  logic signed [CMD_W-1:0]  lat_follow;
  logic signed [CMD_W-1:0]  rot_follow;
  logic signed [9:0]        fwd_count;
  logic signed [9:0]        lat_count;
  logic signed [CMD_W-1:0]  target;
  logic [8:0]               rate;
  logic signed [19:0]       ramp_diff;
  logic signed [29:0]       ramp_prod;
  logic signed [29:0]       ramp_round;
  logic signed [CMD_W-1:0]  fwd_ramp;
  logic                     line_lost;
  logic signed [CMD_W-1:0]  cmd_f;
  logic signed [CMD_W-1:0]  cmd_l;
  logic signed [CMD_W-1:0]  cmd_r;
  logic signed [MIX_W-1:0]  mix_f;
  logic signed [MIX_W-1:0]  mix_l;
  logic signed [MIX_W-1:0]  mix_r;
  logic signed [MIX_W-1:0]  mix_rf;
  logic signed [MIX_W-1:0]  mix_rr;
  logic signed [MIX_W-1:0]  mix_lf;
  logic signed [MIX_W-1:0]  mix_lr;

  always_comb begin
    sens_diff = $signed({2'b00, s1_q.front_sensor}) - $signed({2'b00, s1_q.rear_sensor});
    sens_err  = $signed({3'b000, s1_q.front_sensor}) + $signed({3'b000, s1_q.rear_sensor})
              - $signed({2'b00, line_center_sum_q}) - 11'(offset_rotate_q);
    lat_prod  = CMD_W'($signed({1'b0, gain_lateral_q})) * CMD_W'(sens_diff);
    rot_prod  = CMD_W'($signed({1'b0, gain_rotate_q})) * CMD_W'(sens_err);
    lat_follow = CmdCentre + lat_prod - CMD_W'($signed({offset_lateral_q, 8'b0}));
    rot_follow = CmdCentre + rot_prod;

    fwd_count = 10'sd64 + 10'(s1_q.forward_offset);
    lat_count = 10'sd64 + 10'(s1_q.lateral_offset);
    target    = CMD_W'($signed({fwd_count, 8'b0}));

    // ramp toward target, rate clipped to one, rounded half up
    rate       = (ramp_rate_q > 9'(RATE_ONE)) ? 9'(RATE_ONE) : ramp_rate_q;
    ramp_diff  = 20'(target) - 20'(forward_cmd_q);
    ramp_prod  = 30'(ramp_diff) * 30'($signed({1'b0, rate}));
    ramp_round = ramp_prod + 30'sd128;
    fwd_ramp   = CMD_W'(forward_cmd_q) + CMD_W'($signed(ramp_round[29:8]));

    case (mode_e'(s1_q.mode))
      MODE_STICKS: begin
        cmd_f = $signed({8'b0, s1_q.stick_forward, 8'b0});
        cmd_l = $signed({8'b0, s1_q.stick_lateral, 8'b0});
        cmd_r = $signed({8'b0, s1_q.stick_rotate, 8'b0});
      end
      MODE_RAMP: begin
        cmd_f = fwd_ramp;
        cmd_l = lat_follow;
        cmd_r = rot_follow;
      end
      MODE_FIXED: begin
        cmd_f = target;
        cmd_l = lat_follow;
        cmd_r = rot_follow;
      end
      MODE_SLIDE: begin
        cmd_f = CmdCentre;
        cmd_l = CMD_W'($signed({lat_count, 8'b0}));
        cmd_r = CmdCentre;
      end
      default: begin
        cmd_f = CmdCentre;
        cmd_l = CmdCentre;
        cmd_r = CmdCentre;
      end
    endcase

    // lost line with stop requested centres everything
    line_lost = s1_q.stop_on_line_loss &&
                ((s1_q.front_sensor == line_lost_code_q) ||
                 (s1_q.rear_sensor == line_lost_code_q));
    if (line_lost) begin
      cmd_f = CmdCentre;
      cmd_l = CmdCentre;
      cmd_r = CmdCentre;
    end
    forward_cmd_d = cmd_f[FWD_W-1:0];

    // wheel mixing, signs already folded in
    mix_f  = MIX_W'(cmd_f);
    mix_l  = MIX_W'(cmd_l);
    mix_r  = MIX_W'(cmd_r);
    mix_rf = Mix192 - mix_f - mix_l - mix_r;
    mix_rr = Mix64 - mix_f + mix_l - mix_r;
    mix_lf = mix_l + mix_r - mix_f - Mix64;
    mix_lr = Mix64 - mix_f - mix_l + mix_r;
  end

  drive_t drv_rf;
  drive_t drv_rr;
  drive_t drv_lf;
  drive_t drv_lr;

  mdmlf_wheel_drive #(.DriveLimit(DriveLimit)) u_drive_rf (.mix_i(mix_rf), .drive_o(drv_rf));
  mdmlf_wheel_drive #(.DriveLimit(DriveLimit)) u_drive_rr (.mix_i(mix_rr), .drive_o(drv_rr));
  mdmlf_wheel_drive #(.DriveLimit(DriveLimit)) u_drive_lf (.mix_i(mix_lf), .drive_o(drv_lf));
  mdmlf_wheel_drive #(.DriveLimit(DriveLimit)) u_drive_lr (.mix_i(mix_lr), .drive_o(drv_lr));

  // left wheels run with reversed direction polarity
  always_comb begin
    out_d.rf_magnitude = drv_rf.mag;
    out_d.rf_reverse   = drv_rf.neg;
    out_d.rr_magnitude = drv_rr.mag;
    out_d.rr_reverse   = drv_rr.neg;
    out_d.lf_magnitude = drv_lf.mag;
    out_d.lf_reverse   = drv_lf.pos;
    out_d.lr_magnitude = drv_lr.mag;
    out_d.lr_reverse   = drv_lr.pos;
  end

  // result stage and forward command state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      forward_cmd_q <= FWD_CENTRE;
    end else if (advance) begin
      out_valid_q   <= 1'b1;
      forward_cmd_q <= forward_cmd_d;
    end else if (out_ready_i) begin
      out_valid_q   <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  // checks
  `MDMLF_ASSERT_NXT(a_fwd_hold, clk_i, rst_ni, !advance, $stable(forward_cmd_q))
  `MDMLF_ASSERT_NXT(a_lost_centre, clk_i, rst_ni, advance && line_lost, forward_cmd_q == FWD_CENTRE)
  `MDMLF_ASSERT_NXT(a_fixed_target, clk_i, rst_ni, advance && !line_lost && (s1_q.mode == MODE_FIXED), forward_cmd_q == $past(target[FWD_W-1:0]))
  `MDMLF_ASSERT_NXT(a_result_loaded, clk_i, rst_ni, advance, out_valid_o)
  `MDMLF_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, !in_ready_o, s1_valid_q && out_valid_q && !out_ready_i)

endmodule

### bench/mdmlf_wheel_check.sv
// wheel level predictor and result checker for the mecanum mixer bench
// depends on mdmlf_pkg; watches the in, out and cfg channels of the block
`timescale 1ns / 1ps

module mdmlf_wheel_check #(
  parameter int unsigned DriveLimit = mdmlf_pkg::DRIVE_LIMIT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  mdmlf_pkg::in_t                   in_data_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  mdmlf_pkg::out_t                  out_data_i,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [mdmlf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mdmlf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                      mismatch_count_o,
  output int unsigned                      pending_o
);

  import mdmlf_pkg::*;

  localparam longint ONE_Q8 = 256;
  localparam longint MID_Q8 = 64 * ONE_Q8;

  logic [11:0]              gain_lat;
  logic [11:0]              gain_rot;
  logic signed [7:0]        trim_lat;
  logic signed [7:0]        trim_rot;
  logic [8:0]               centre_sum;
  logic [7:0]               lost_code;
  logic [8:0]               ramp;
  logic signed [FWD_W-1:0]  fwd_state;

  out_t        expected_wheels[$];
  int unsigned mismatches = 0;

  assign mismatch_count_o = mismatches;

  // truncate toward zero, saturate, split into {magnitude, reverse}
  function automatic logic [8:0] wheel_level(longint mix, bit left);
    longint v;
    longint m;
    v = mix / ONE_Q8;
    if (v > longint'(DriveLimit)) v = longint'(DriveLimit);
    if (v < -longint'(DriveLimit)) v = -longint'(DriveLimit);
    if (v == 0) return 9'd0;
    m = (v < 0) ? -v : v;
    if (m > longint'(MAG_MAX)) m = longint'(MAG_MAX);
    return {m[7:0], left ? (v > 0) : (v < 0)};
  endfunction

  // commands for one tick, updates the stored forward command
  function automatic out_t mix_tick(in_t t);
    longint fwd;
    longint lat;
    longint rot;
    longint target;
    longint rate;
    longint fr;
    longint rr;
    logic   lost;
    out_t   r;
    fr = longint'(t.front_sensor);
    rr = longint'(t.rear_sensor);
    case (mode_e'(t.mode))
      MODE_STICKS: begin
        fwd = longint'(t.stick_forward) * ONE_Q8;
        lat = longint'(t.stick_lateral) * ONE_Q8;
        rot = longint'(t.stick_rotate) * ONE_Q8;
      end
      MODE_SLIDE: begin
        fwd = MID_Q8;
        lat = (64 + longint'($signed(t.lateral_offset))) * ONE_Q8;
        rot = MID_Q8;
      end
      default: begin
        target = (64 + longint'($signed(t.forward_offset))) * ONE_Q8;
        lat = MID_Q8 + longint'(gain_lat) * (fr - rr) - longint'(trim_lat) * ONE_Q8;
        rot = MID_Q8 + longint'(gain_rot) *
              (fr + rr - longint'(centre_sum) - longint'(trim_rot));
        if (mode_e'(t.mode) == MODE_RAMP) begin
          rate = (ramp > RATE_ONE) ? longint'(RATE_ONE) : longint'(ramp);
          fwd = longint'(fwd_state) +
                (((target - longint'(fwd_state)) * rate + 128) >>> 8);
        end else begin
          fwd = target;
        end
      end
    endcase
    lost = t.stop_on_line_loss &&
           (t.front_sensor == lost_code || t.rear_sensor == lost_code);
    if (lost) begin
      fwd = MID_Q8;
      lat = MID_Q8;
      rot = MID_Q8;
    end
    fwd_state = fwd[FWD_W-1:0];
    {r.rf_magnitude, r.rf_reverse} = wheel_level(-(fwd + lat - 128 * ONE_Q8 + rot - MID_Q8), 0);
    {r.rr_magnitude, r.rr_reverse} = wheel_level(-(fwd - lat + rot - MID_Q8), 0);
    {r.lf_magnitude, r.lf_reverse} = wheel_level(-(fwd - lat - rot + MID_Q8), 1);
    {r.lr_magnitude, r.lr_reverse} = wheel_level(-(fwd + lat - 128 * ONE_Q8 - rot + MID_Q8), 1);
    return r;
  endfunction

  task automatic check_field(string field, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t %s: expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      gain_lat   = RST_GAIN_LATERAL;
      gain_rot   = RST_GAIN_ROTATE;
      trim_lat   = RST_OFFSET_LATERAL;
      trim_rot   = RST_OFFSET_ROTATE;
      centre_sum = RST_LINE_CENTER_SUM;
      lost_code  = RST_LINE_LOST_CODE;
      ramp       = RST_RAMP_RATE;
      fwd_state  = FWD_CENTRE;
      expected_wheels.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_GAIN_LATERAL:    gain_lat   = cfg_data_i;
          CFG_GAIN_ROTATE:     gain_rot   = cfg_data_i;
          CFG_OFFSET_LATERAL:  trim_lat   = cfg_data_i[7:0];
          CFG_OFFSET_ROTATE:   trim_rot   = cfg_data_i[7:0];
          CFG_LINE_CENTER_SUM: centre_sum = cfg_data_i[8:0];
          CFG_LINE_LOST_CODE:  lost_code  = cfg_data_i[7:0];
          CFG_RAMP_RATE:       ramp       = cfg_data_i[8:0];
          default: ;
        endcase
      end
      // results first: a tick never produces its result at its own accept edge
      if (out_valid_i && out_ready_i) begin
        if (expected_wheels.size() == 0) begin
          mismatches++;
          $display("%0t result transaction with nothing expected", $time);
        end else begin
          want = expected_wheels.pop_front();
          check_field("rf_magnitude", want.rf_magnitude, out_data_i.rf_magnitude);
          check_field("rf_reverse", want.rf_reverse, out_data_i.rf_reverse);
          check_field("rr_magnitude", want.rr_magnitude, out_data_i.rr_magnitude);
          check_field("rr_reverse", want.rr_reverse, out_data_i.rr_reverse);
          check_field("lf_magnitude", want.lf_magnitude, out_data_i.lf_magnitude);
          check_field("lf_reverse", want.lf_reverse, out_data_i.lf_reverse);
          check_field("lr_magnitude", want.lr_magnitude, out_data_i.lr_magnitude);
          check_field("lr_reverse", want.lr_reverse, out_data_i.lr_reverse);
        end
      end
      if (in_valid_i && in_ready_i) expected_wheels.push_back(mix_tick(in_data_i));
    end
    pending_o <= expected_wheels.size();
  end

endmodule

### bench/mecanum_drive_mixer_line_follow_tb.sv
// top of the mecanum mixer bench: clock, reset, stimulus and verdict
// depends on mdmlf_pkg, the block under test and mdmlf_wheel_check
`timescale 1ns / 1ps

module mecanum_drive_mixer_line_follow_tb;

  import mdmlf_pkg::*;

  // index past the register file, the block must ignore writes to it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned mismatch_count;
  int unsigned pending;

  // idle stretches per side, counts down transactions with no gap
  int in_calm  = 0;
  int out_calm = 0;

  // stimulus copy of the registers that steer sensor values
  logic [7:0] lost_now   = RST_LINE_LOST_CODE;
  logic [8:0] centre_now = RST_LINE_CENTER_SUM;

  mecanum_drive_mixer_line_follow u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  mdmlf_wheel_check u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // random gap before the next transaction, with calm stretches of none
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 4);
  endfunction

  function automatic in_t mk_tick(mode_e m, logic [7:0] front, logic [7:0] rear,
                                  logic [7:0] sf, logic [7:0] sl, logic [7:0] sr,
                                  logic signed [7:0] fo, logic signed [7:0] lo,
                                  logic stop);
    in_t t;
    t.mode              = m;
    t.front_sensor      = front;
    t.rear_sensor       = rear;
    t.stick_forward     = sf;
    t.stick_lateral     = sl;
    t.stick_rotate      = sr;
    t.forward_offset    = fo;
    t.lateral_offset    = lo;
    t.stop_on_line_loss = stop;
    return t;
  endfunction

  // sensor reading near half the centred sum, so corrections stay unsaturated
  function automatic logic [7:0] near_half(int centre);
    int v;
    v = centre / 2 + int'($urandom_range(0, 16)) - 8;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic in_t rand_tick(mode_e m, logic signed [7:0] fo);
    logic [63:0] raw;
    in_t         t;
    raw = {$urandom, $urandom};
    t = raw[$bits(in_t)-1:0];
    t.mode = m;
    t.forward_offset = fo;
    case ($urandom_range(0, 7))
      0: t.front_sensor = lost_now;
      1: t.rear_sensor  = lost_now;
      2, 3: begin
        t.front_sensor = near_half(int'(centre_now));
        t.rear_sensor  = near_half(int'(centre_now));
      end
      default: ;
    endcase
    return t;
  endfunction

  // one tick transaction; valid stays high when the next one follows at once
  task automatic send_tick(input in_t t);
    int gap;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and wait until every tick has its result back
  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // register write; valid is left high for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // full register set, junk in the upper bits the block must drop
  task automatic program_regs(input logic [11:0] gl, input logic [11:0] gr,
                              input logic signed [7:0] ol, input logic signed [7:0] orot,
                              input logic [8:0] cs, input logic [7:0] lc,
                              input logic [8:0] rr);
    write_reg(CFG_UNUSED_IDX, 12'($urandom));
    write_reg(CFG_GAIN_LATERAL, gl);
    write_reg(CFG_GAIN_ROTATE, gr);
    write_reg(CFG_OFFSET_LATERAL, {4'($urandom), ol});
    write_reg(CFG_OFFSET_ROTATE, {4'($urandom), orot});
    write_reg(CFG_LINE_CENTER_SUM, {3'($urandom), cs});
    write_reg(CFG_LINE_LOST_CODE, {4'($urandom), lc});
    write_reg(CFG_RAMP_RATE, {3'($urandom), rr});
    cfg_valid <= 1'b0;
    lost_now   = lc;
    centre_now = cs;
  endtask

  // runs of one mode, mostly ramp runs with a steady target so the ramp settles
  task automatic run_phase(input int n);
    int                left;
    int                run;
    mode_e             m;
    logic signed [7:0] fo;
    left = n;
    while (left > 0) begin
      m = mode_e'($urandom_range(0, 3));
      if ($urandom_range(0, 1) == 1) m = MODE_RAMP;
      fo  = 8'($urandom);
      run = $urandom_range(1, 24);
      for (int k = 0; k < run && left > 0; k++) begin
        send_tick(rand_tick(m, ($urandom_range(0, 5) == 0) ? 8'($urandom) : fo));
        left--;
      end
    end
  endtask

  // result side: stalls drawn per transaction
  initial begin : receiver
    int gap;
    wait (rst_n);
    forever begin
      gap = draw_gap(out_calm);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed ticks at the reset register values
    // all centred sticks: every wheel at zero drive
    send_tick(mk_tick(MODE_STICKS, 8'd0, 8'd0, 8'd64, 8'd64, 8'd64, 8'sd0, 8'sd0, 1'b0));
    send_tick(mk_tick(MODE_STICKS, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                      8'sd127, 8'sd127, 1'b1));
    send_tick(mk_tick(MODE_STICKS, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, -8'sd128, -8'sd128, 1'b0));
    send_tick(mk_tick(MODE_STICKS, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'sd0, 8'sd0, 1'b0));
    // ramp toward both extremes of the forward offset
    repeat (3) send_tick(mk_tick(MODE_RAMP, 8'd63, 8'd63, 8'd0, 8'd0, 8'd0,
                                 8'sd127, 8'sd0, 1'b0));
    repeat (2) send_tick(mk_tick(MODE_RAMP, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0,
                                 -8'sd128, 8'sd0, 1'b0));
    // fixed speed with extreme offsets and sensor differences
    send_tick(mk_tick(MODE_FIXED, 8'd63, 8'd63, 8'd0, 8'd0, 8'd0, 8'sd127, 8'sd0, 1'b0));
    send_tick(mk_tick(MODE_FIXED, 8'd63, 8'd63, 8'd0, 8'd0, 8'd0, -8'sd128, 8'sd0, 1'b0));
    send_tick(mk_tick(MODE_FIXED, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'sd0, 8'sd0, 1'b0));
    send_tick(mk_tick(MODE_FIXED, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'sd0, 8'sd0, 1'b0));
    // slide both ways and in place
    send_tick(mk_tick(MODE_SLIDE, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'sd0, 8'sd127, 1'b0));
    send_tick(mk_tick(MODE_SLIDE, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'sd0, -8'sd128, 1'b0));
    send_tick(mk_tick(MODE_SLIDE, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'sd0, 8'sd0, 1'b0));
    // line lost on either sensor with stop set, then with stop clear
    send_tick(mk_tick(MODE_RAMP, lost_now, 8'd100, 8'd0, 8'd0, 8'd0, 8'sd90, 8'sd0, 1'b1));
    send_tick(mk_tick(MODE_STICKS, 8'd100, lost_now, 8'd200, 8'd9, 8'd140,
                      8'sd0, 8'sd0, 1'b1));
    send_tick(mk_tick(MODE_SLIDE, lost_now, lost_now, 8'd0, 8'd0, 8'd0, 8'sd0, 8'sd100, 1'b1));
    send_tick(mk_tick(MODE_FIXED, lost_now, 8'd60, 8'd0, 8'd0, 8'd0, 8'sd50, 8'sd0, 1'b0));
    // ramp starts from the forward command left by the fixed-speed tick before
    repeat (2) send_tick(mk_tick(MODE_RAMP, 8'd60, 8'd66, 8'd0, 8'd0, 8'd0,
                                 8'sd100, 8'sd0, 1'b0));
    run_phase(200);
    drain();

    // top extremes, ramp rate above one
    program_regs(12'd4095, 12'd4095, 8'sd127, 8'sd127, 9'd511, 8'd255, 9'd511);
    run_phase(150);
    drain();

    // bottom extremes, ramp rate zero holds the forward command
    program_regs(12'd0, 12'd0, -8'sd128, -8'sd128, 9'd0, 8'd0, 9'd0);
    run_phase(150);
    drain();

    // ramp rate of exactly one
    program_regs(12'd230, 12'd205, -8'sd1, 8'sd5, 9'd126, 8'd21, 9'd256);
    run_phase(150);
    drain();

    // random settings, mostly moderate gains
    repeat (4) begin
      program_regs(($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 600)),
                   ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 600)),
                   8'($urandom), 8'($urandom), 9'($urandom_range(0, 511)),
                   8'($urandom), 9'($urandom_range(0, 300)));
      run_phase(150);
      drain();
    end

    // let any stray result transaction show up
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/mdmlf_pkg.sv
src/mdmlf_wheel_drive.sv
src/mecanum_drive_mixer_line_follow.sv
bench/mdmlf_wheel_check.sv
bench/mecanum_drive_mixer_line_follow_tb.sv
